// ----- design/fsa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types and constants of the free-list slot allocator.
// ----------------------------------------------------------------------------
package fsa_pkg;

   localparam int SLOTS     = 256;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int COUNT_W   = SLOT_W + 1;
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   localparam logic [COUNT_W-1:0] SLOTS_COUNT    = COUNT_W'(SLOTS);
   localparam logic [COUNT_W-1:0] POOL_CAP_RESET = COUNT_W'(SLOTS);
   localparam logic [COUNT_W-1:0] FREE_MAX       = {COUNT_W{1'b1}};

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [1:0] ST_RANGE     = 2'd2;

   localparam logic [2:0] KIND_ALLOC    = 3'd0;
   localparam logic [2:0] KIND_FREE     = 3'd1;
   localparam logic [2:0] KIND_FREE_BAD = 3'd2;
   localparam logic [2:0] KIND_CLEAR    = 3'd3;
   localparam logic [2:0] KIND_NOP      = 3'd4;

   typedef struct packed {
      logic [1:0]        op;
      logic [SLOT_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  granted_slot;
      logic [1:0]         status;
      logic [COUNT_W-1:0] live_count;
   } rsp_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [SLOT_W-1:0] slot;
   } cmd_type;

endpackage
`default_nettype wire

// ----- design/fsa_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fsa_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module fsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- design/fsa_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fsa_front
// Accepts request transactions, classifies them and queues them for the
// execution side.
// ----------------------------------------------------------------------------
module fsa_front
   import fsa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [COUNT_W-1:0] capacity,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_data,
   output logic                    cmd_valid,
   input  wire logic               cmd_ready,
   output cmd_type                 cmd_data
);

   cmd_type                cmd_q_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;
   cmd_type                cmd_new;
   logic                   push;
   logic                   pop;

   always_comb begin
      cmd_new.slot = req_data.slot_index;
      case (req_data.op)
         OP_ALLOC: cmd_new.kind = KIND_ALLOC;
         OP_FREE: begin
            if ({1'b0, req_data.slot_index} >= capacity) begin
               cmd_new.kind = KIND_FREE_BAD;
            end else begin
               cmd_new.kind = KIND_FREE;
            end
         end
         OP_CLEAR: cmd_new.kind = KIND_CLEAR;
         default:  cmd_new.kind = KIND_NOP;
      endcase
   end

   assign req_ready = (count_ff != CMD_CNT_W'(CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = cmd_q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + CMD_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + CMD_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CMD_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule
`default_nettype wire

// ----- design/fsa_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fsa_back
// Executes queued commands against the free list and the high-water mark,
// and holds the response register.
// ----------------------------------------------------------------------------
module fsa_back
   import fsa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [COUNT_W-1:0] capacity,
   input  wire logic               cmd_valid,
   output logic                    cmd_ready,
   input  wire cmd_type            cmd_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_POP  = 1'b1;

   logic               state_ff, state_in;
   logic [SLOT_W-1:0]  head_ff, head_in;
   logic [COUNT_W-1:0] high_water_ff, high_water_in;
   logic [COUNT_W-1:0] free_total_ff, free_total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [COUNT_W-1:0] cap_eff;
   logic               out_free;
   logic               emit;
   logic [SLOT_W-1:0]  granted;
   logic [1:0]         status;
   logic               rd_en;
   logic               wr_en;
   logic [SLOT_W-1:0]  rd_data;

   assign cap_eff  = (capacity > SLOTS_COUNT) ? SLOTS_COUNT : capacity;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      high_water_in = high_water_ff;
      free_total_in = free_total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      cmd_ready     = 1'b0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      emit          = 1'b0;
      granted       = '0;
      status        = ST_OK;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_ready = 1'b1;
               case (cmd_data.kind)
                  KIND_ALLOC: begin
                     if (free_total_ff != '0) begin
                        rd_en    = 1'b1;
                        state_in = ST_POP;
                     end else if (high_water_ff < cap_eff) begin
                        granted       = high_water_ff[SLOT_W-1:0];
                        high_water_in = high_water_ff + COUNT_W'(1);
                        emit          = 1'b1;
                     end else begin
                        status = ST_EXHAUSTED;
                        emit   = 1'b1;
                     end
                  end
                  KIND_FREE: begin
                     emit = 1'b1;
                     if (free_total_ff != FREE_MAX) begin
                        wr_en         = 1'b1;
                        head_in       = cmd_data.slot;
                        free_total_in = free_total_ff + COUNT_W'(1);
                     end
                  end
                  KIND_FREE_BAD: begin
                     status = ST_RANGE;
                     emit   = 1'b1;
                  end
                  KIND_CLEAR: begin
                     head_in       = '0;
                     high_water_in = '0;
                     free_total_in = '0;
                     emit          = 1'b1;
                  end
                  default: emit = 1'b1;
               endcase
            end
         end
         ST_POP: begin
            if (out_free) begin
               granted       = head_ff;
               head_in       = rd_data;
               free_total_in = free_total_ff - COUNT_W'(1);
               emit          = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (emit) begin
         rsp_valid_in        = 1'b1;
         rsp_in.granted_slot = granted;
         rsp_in.status       = status;
         rsp_in.live_count   = (high_water_in > free_total_in) ?
                               high_water_in - free_total_in : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         high_water_ff <= '0;
         free_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         high_water_ff <= high_water_in;
         free_total_ff <= free_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   fsa_ram #(
      .WIDTH(SLOT_W),
      .DEPTH(SLOTS)
   ) u_next_link (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cmd_data.slot),
      .wr_data (head_ff),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_pop_needs_list: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP |-> free_total_ff != '0)
      else $error("list pop pending with an empty free list");

   a_pop_completes: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP && out_free |=> state_ff == ST_IDLE && rsp_valid_ff)
      else $error("list pop did not complete with a response");

   a_no_grant_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_OK |-> rsp_ff.granted_slot == '0)
      else $error("slot granted together with an error status");

   a_high_water_bound: assert property (@(posedge clock) disable iff (reset)
      high_water_ff <= SLOTS_COUNT)
      else $error("high-water mark beyond the slot count");

   a_no_take_in_pop: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP |-> !cmd_ready)
      else $error("command taken while a list pop is pending");

endmodule
`default_nettype wire

// ----- design/free_list_slot_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// free_list_slot_allocator
// Fixed-size slot allocator built on a LIFO free list with in-slot links.
//
// A request transaction carries an op (allocate, free, reset pool) and a
// slot index; every request yields exactly one response transaction with the
// granted slot, a status and the live slot count after the operation.
// The csr channel writes the pool capacity; it resets to the full slot count.
// The user must see that it is written only while no transaction is in
// flight; the block does not enforce this. A front stage classifies requests
// into a two-entry command queue, and a back stage executes them against the
// free list and the high-water mark; an allocate served from the free list
// also waits in ST_POP for the registered read of the next-link RAM. The back
// stage takes one command per cycle while its output register is free, but
// none in ST_POP. Responses sit in an output register, so a stalled receiver
// lets the queue keep filling until it is full.
// Synchronous reset empties the pool and the queue and restores capacity.
// ----------------------------------------------------------------------------
module free_list_slot_allocator
   import fsa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [COUNT_W-1:0] csr_data
);

   logic [COUNT_W-1:0] capacity_ff, capacity_in;
   logic               cmd_valid;
   logic               cmd_ready;
   cmd_type            cmd_data;

   assign csr_ready   = 1'b1;
   assign capacity_in = (csr_valid && csr_ready) ? csr_data : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= POOL_CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   fsa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .capacity  (capacity_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   fsa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .capacity  (capacity_ff),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ----- test/fsa_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fsa_checker
// Watches the request, response and csr channels of the slot allocator. For
// every accepted request it predicts the response from its own copy of the
// free list, the high-water mark and the pool capacity, and compares every
// accepted response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module fsa_checker
   import fsa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  req_type            req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  rsp_type            rsp_data,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data,
   output int                 mismatches,
   output int                 outstanding,
   output int                 responses,
   output int                 exhausted_seen,
   output int                 range_seen,
   output int                 pops_seen,
   output int                 dropped_seen
);

   logic [SLOT_W-1:0]  link_ram [SLOTS];
   logic [SLOT_W-1:0]  head;
   logic               listed;
   logic [COUNT_W-1:0] fresh_mark;
   logic [COUNT_W-1:0] listed_total;
   logic [COUNT_W-1:0] capacity;
   rsp_type            expected_q [$];

   task automatic predict_response(input req_type item, output rsp_type result);
      logic [COUNT_W-1:0] usable;
      usable = (capacity > SLOTS_COUNT) ? SLOTS_COUNT : capacity;
      result = '0;
      result.status = ST_OK;
      case (item.op)
         OP_ALLOC: begin
            if (listed && listed_total != '0) begin
               result.granted_slot = head;
               head = link_ram[head];
               listed_total = listed_total - COUNT_W'(1);
               listed = (listed_total != '0);
               pops_seen++;
            end else if (fresh_mark < usable) begin
               result.granted_slot = fresh_mark[SLOT_W-1:0];
               fresh_mark = fresh_mark + COUNT_W'(1);
            end else begin
               result.status = ST_EXHAUSTED;
               exhausted_seen++;
            end
         end
         OP_FREE: begin
            if ({1'b0, item.slot_index} >= usable) begin
               result.status = ST_RANGE;
               range_seen++;
            end else if (listed_total < FREE_MAX) begin
               link_ram[item.slot_index] = head;
               head = item.slot_index;
               listed_total = listed_total + COUNT_W'(1);
               listed = 1'b1;
            end else begin
               dropped_seen++;
            end
         end
         OP_CLEAR: begin
            head = '0;
            listed = 1'b0;
            fresh_mark = '0;
            listed_total = '0;
         end
         default: begin
         end
      endcase
      result.live_count = (fresh_mark > listed_total) ? fresh_mark - listed_total : '0;
   endtask

   task automatic report_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("Mismatch (%s) at %0t: expected slot %0d status %0d live %0d,",
                  what, $realtime, want.granted_slot, want.status, want.live_count,
                  " got slot %0d status %0d live %0d",
                  got.granted_slot, got.status, got.live_count);
      end
   endtask

   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type oldest;
      if (reset) begin
         head = '0;
         listed = 1'b0;
         fresh_mark = '0;
         listed_total = '0;
         capacity = POOL_CAP_RESET;
         expected_q.delete();
         mismatches = 0;
         responses = 0;
         exhausted_seen = 0;
         range_seen = 0;
         pops_seen = 0;
         dropped_seen = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity = csr_data;
         end
         if (req_valid && req_ready) begin
            predict_response(req_data, predicted);
            expected_q.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            responses++;
            if (expected_q.size() == 0) begin
               report_mismatch("no request pending", '0, rsp_data);
            end else begin
               oldest = expected_q.pop_front();
               if (rsp_data.granted_slot !== oldest.granted_slot ||
                   rsp_data.status !== oldest.status ||
                   rsp_data.live_count !== oldest.live_count) begin
                  report_mismatch("field", oldest, rsp_data);
               end
            end
         end
      end
      outstanding = expected_q.size();
   end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the slot allocator with a directed opening and then random request
// traffic under several capacities and idle patterns, including a long
// response stall and a flood of frees that saturates the free count. The
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
   import fsa_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam int         HOLD_CYCLES  = 60;
   localparam int         DRAIN_CYCLES = 4;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_type            req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_type            rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data = '0;

   int mismatches;
   int outstanding;
   int responses;
   int exhausted_seen;
   int range_seen;
   int pops_seen;
   int dropped_seen;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int cycle_count = 0;

   free_list_slot_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   fsa_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .responses      (responses),
      .exhausted_seen (exhausted_seen),
      .range_seen     (range_seen),
      .pops_seen      (pops_seen),
      .dropped_seen   (dropped_seen)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, outstanding);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // The response side stalls at random, and on request holds off for a long stretch.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   task automatic push_request(input req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_op(input logic [1:0] op, input logic [SLOT_W-1:0] slot);
      req_type item;
      item.op = op;
      item.slot_index = slot;
      push_request(item);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_capacity(input logic [COUNT_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type random_request(input int cap);
      req_type item;
      int roll;
      int usable;
      usable = (cap > SLOTS) ? SLOTS : cap;
      roll = $urandom_range(0, 99);
      item.slot_index = SLOT_W'($urandom_range(0, 255));
      if (roll < 50) begin
         item.op = OP_ALLOC;
      end else if (roll < 88) begin
         item.op = OP_FREE;
         item.slot_index = SLOT_W'($urandom_range(0, usable - 1));
      end else if (roll < 93) begin
         item.op = OP_FREE;
         if (usable < SLOTS) item.slot_index = SLOT_W'($urandom_range(usable, 255));
      end else if (roll < 97) begin
         item.op = OP_CLEAR;
      end else begin
         item.op = OP_UNUSED;
      end
      return item;
   endfunction

   task automatic run_phase(input int idle, input int stall, input int cap, input int count);
      set_capacity(COUNT_W'(cap));
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (count) push_request(random_request(cap));
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_op(OP_ALLOC, 8'hFF);
      send_op(OP_ALLOC, 8'h00);
      send_op(OP_ALLOC, 8'h00);
      send_op(OP_FREE, 8'd1);
      send_op(OP_FREE, 8'hFF);
      send_op(OP_ALLOC, 8'h00);
      send_op(OP_ALLOC, 8'h00);
      send_op(OP_FREE, 8'd0);
      send_op(OP_FREE, 8'd0);
      send_op(OP_ALLOC, 8'h00);
      send_op(OP_ALLOC, 8'h00);
      send_op(OP_UNUSED, 8'hAA);
      send_op(OP_FREE, 8'd200);
      set_capacity(9'd4);
      send_op(OP_ALLOC, 8'h00);
      send_op(OP_ALLOC, 8'h00);
      send_op(OP_FREE, 8'd4);
      send_op(OP_CLEAR, 8'h55);
      send_op(OP_FREE, 8'd2);
      set_capacity(9'd1);
      send_op(OP_CLEAR, 8'h00);
      send_op(OP_ALLOC, 8'h00);
      send_op(OP_ALLOC, 8'h00);
      send_op(OP_FREE, 8'd1);
      set_capacity(9'd0);
      send_op(OP_ALLOC, 8'h00);
      send_op(OP_FREE, 8'd0);
      set_capacity(9'd511);
      send_op(OP_FREE, 8'hFF);
      send_op(OP_ALLOC, 8'h00);
      send_op(OP_ALLOC, 8'h00);

      run_phase(0, 0, 8, 130);
      run_phase(66, 0, 256, 130);
      run_phase(0, 66, 32, 130);
      run_phase(7, 7, 3, 130);

      // Flood of frees past the limit of the free count, then pops.
      set_capacity(9'd256);
      send_idle_pct = 0;
      stall_pct = 0;
      send_op(OP_CLEAR, 8'h00);
      repeat (10) send_op(OP_ALLOC, 8'h00);
      repeat (520) send_op(OP_FREE, SLOT_W'($urandom_range(0, 255)));
      repeat (20) send_op(OP_ALLOC, SLOT_W'($urandom_range(0, 255)));

      set_capacity(9'd16);
      hold_requests++;
      repeat (60) push_request(random_request(16));

      settle();
      $display("Covered %0d responses at capacities 0, 1, 3, 4, 8, 16, 32, 256 and 511",
               responses);
      $display("with %0d list pops, %0d exhausted allocs, %0d bad frees, %0d dropped frees.",
               pops_seen, exhausted_seen, range_seen, dropped_seen);
      if (mismatches == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/fsa_pkg.sv
design/fsa_ram.sv
design/fsa_front.sv
design/fsa_back.sv
design/free_list_slot_allocator.sv
test/fsa_checker.sv
test/testbench.sv
